### hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros shared by the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// clocked assertion that also runs during reset
`define ASSERT_CLK_NR(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/salru_pkg.sv
// ----------------------------------------------------------------------------
// salru_pkg
// Shared types and constants of the set associative tag and replacement block.
// ----------------------------------------------------------------------------
`default_nettype none

package salru_pkg;

    localparam int MAX_INDEX_BITS = 6;
    localparam int MAX_WAYS       = 4;
    localparam int NUM_SETS       = 1 << MAX_INDEX_BITS;
    localparam int SET_W          = MAX_INDEX_BITS;
    localparam int WAY_W          = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

    localparam int ADDR_W   = 32;
    localparam int TAG_W    = 32;
    localparam int CNT_W    = 32;
    localparam int OUT_WAY_W = 2;
    localparam int OUT_SET_W = 6;

    localparam int OFF_CFG_W  = 5;
    localparam int IDX_CFG_W  = 3;
    localparam int WAYS_CFG_W = 3;
    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 2;
    localparam int SH_W       = OFF_CFG_W + 1;

    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_BITS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INDEX_BITS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_REPLACE_MODE = 2'd3;

    localparam logic [OFF_CFG_W-1:0]  RST_OFFSET_BITS = 5'd3;
    localparam logic [IDX_CFG_W-1:0]  RST_INDEX_BITS  = 3'd4;
    localparam logic [WAYS_CFG_W-1:0] RST_WAYS_IN_USE = 3'd1;

    localparam logic MODE_FIFO = 1'b0;
    localparam logic MODE_LRU  = 1'b1;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } t_state;

    typedef struct packed {
        logic clear;
        logic load;
        logic commit;
    } t_ctrl_cmd;

endpackage

`default_nettype wire

### hdl/set_assoc_cache_tag_lru.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_tag_lru
// Tag lookup of a set associative cache with round robin or LRU replacement.
// ----------------------------------------------------------------------------
// When an item is accepted, the selected set is read from the tag, valid,
// stamp and round robin pointer RAMs into their registered read ports; in
// the lookup state the ways are compared, the victim is chosen, the set is
// written back and the result register is loaded. The next item is accepted
// once the update is written. A result that waits in the result register
// does not hold off acceptance, but a second result waits in the lookup
// state until the first is taken. After reset the RAMs are cleared one set
// per cycle, and the input stays stalled until all 64 sets are cleared.
`default_nettype none

module set_assoc_cache_tag_lru import salru_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [ADDR_W-1:0]     i_address,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic                       o_hit,
    output logic [OUT_WAY_W-1:0]       o_way,
    output logic [OUT_SET_W-1:0]       o_set_index,
    output logic [CNT_W-1:0]           o_hits_so_far,
    output logic [CNT_W-1:0]           o_accesses_so_far
);

    t_ctrl_cmd cmd;
    logic      clr_last;

    salru_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_out_stall (i_out_stall),
        .i_clr_last  (clr_last),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    salru_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_wr_en       (i_cfg_wr_en),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_address         (i_address),
        .i_cmd             (cmd),
        .o_clr_last        (clr_last),
        .o_hit             (o_hit),
        .o_way             (o_way),
        .o_set_index       (o_set_index),
        .o_hits_so_far     (o_hits_so_far),
        .o_accesses_so_far (o_accesses_so_far)
    );

endmodule

`default_nettype wire

### hdl/salru_ram.sv
// ----------------------------------------------------------------------------
// salru_ram
// Simple dual port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

### hdl/salru_ctrl.sv
// ----------------------------------------------------------------------------
// salru_ctrl
// Sequencer: clears the set RAMs after reset, accepts an item, waits for the
// set read, then commits the update.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_ctrl import salru_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    input  wire logic i_out_stall,
    input  wire logic i_clr_last,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_ctrl_cmd o_cmd
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_blocked;

    assign out_blocked = r_out_valid & i_out_stall;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_clr_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_LOOKUP;
                end
            end
            ST_LOOKUP: begin
                if (!out_blocked) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd      = '0;
        o_in_stall = 1'b1;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
            end
            ST_IDLE: begin
                o_in_stall = 1'b0;
                o_cmd.load = i_in_valid;
            end
            ST_LOOKUP: begin
                o_cmd.commit = !out_blocked;
            end
            default: begin
                o_in_stall = 1'b1;
            end
        endcase
    end

    assign n_out_valid = o_cmd.commit | out_blocked;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

### hdl/salru_dp.sv
// ----------------------------------------------------------------------------
// salru_dp
// Datapath: address split, set memories, hit search, victim choice, counters.
// ----------------------------------------------------------------------------
`default_nettype none

module salru_dp import salru_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    input  wire logic [ADDR_W-1:0]     i_address,
    input  wire t_ctrl_cmd             i_cmd,
    output logic                       o_clr_last,
    output logic                       o_hit,
    output logic [OUT_WAY_W-1:0]       o_way,
    output logic [OUT_SET_W-1:0]       o_set_index,
    output logic [CNT_W-1:0]           o_hits_so_far,
    output logic [CNT_W-1:0]           o_accesses_so_far
);

    localparam int ROW_W = MAX_WAYS * TAG_W;
    localparam int STAMP_ROW_W = MAX_WAYS * CNT_W;

    logic [OFF_CFG_W-1:0]  r_offset_bits;
    logic [IDX_CFG_W-1:0]  r_index_bits;
    logic [WAYS_CFG_W-1:0] r_ways_in_use;
    logic                  r_replace_mode;

    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;
    logic [CNT_W-1:0] r_hits, r_accesses;
    logic [SET_W-1:0] r_clr_set;

    logic [IDX_CFG_W-1:0] ib;
    logic [ADDR_W-1:0]    addr_sh;
    logic [SET_W-1:0]     set_mask;
    logic [SET_W-1:0]     c_set;
    logic [SH_W-1:0]      tag_sh;
    logic [TAG_W-1:0]     c_tag;
    logic [SET_W-1:0]     rd_set;
    logic [SET_W-1:0]     wr_set;

    logic [ROW_W-1:0]       tag_rd, tag_wr;
    logic [STAMP_ROW_W-1:0] stamp_rd, stamp_wr;
    logic [MAX_WAYS-1:0]    vld_rd, vld_wr;
    logic [WAY_W-1:0]       ptr_rd, ptr_wr;

    logic [MAX_WAYS-1:0] way_en, tvld, match, inv, win;
    logic [CNT_W-1:0]    stamp [MAX_WAYS];
    logic                hit, any_inv;
    logic [WAY_W-1:0]    hit_way, inv_way, lru_way, fifo_way, pick;
    logic [WAY_W-1:0]    p_raw;
    logic [WAY_W:0]      p_inc;
    logic                p_ok, inc_ok;
    logic [CNT_W-1:0]    acc_nxt, hits_nxt;
    logic                tag_we, stamp_we, ptr_we;

    // address split
    assign ib       = (r_index_bits > IDX_CFG_W'(MAX_INDEX_BITS)) ?
                      IDX_CFG_W'(MAX_INDEX_BITS) : r_index_bits;
    assign addr_sh  = i_address >> r_offset_bits;
    assign set_mask = ~({SET_W{1'b1}} << ib);
    assign c_set    = addr_sh[SET_W-1:0] & set_mask;
    assign tag_sh   = {1'b0, r_offset_bits} + SH_W'(ib);
    assign c_tag    = i_address >> tag_sh;
    assign rd_set   = i_cmd.load ? c_set : r_set;

    // clearing pass walks every set once after reset
    assign wr_set     = i_cmd.clear ? r_clr_set : r_set;
    assign o_clr_last = (r_clr_set == SET_W'(NUM_SETS - 1));

    salru_ram #(.WIDTH(ROW_W), .DEPTH(NUM_SETS)) u_tag_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_we),
        .i_wr_addr (wr_set),
        .i_wr_data (tag_wr),
        .i_rd_addr (rd_set),
        .o_rd_data (tag_rd)
    );

    salru_ram #(.WIDTH(MAX_WAYS), .DEPTH(NUM_SETS)) u_vld_ram (
        .i_clk     (i_clk),
        .i_wr_en   (tag_we),
        .i_wr_addr (wr_set),
        .i_wr_data (vld_wr),
        .i_rd_addr (rd_set),
        .o_rd_data (vld_rd)
    );

    salru_ram #(.WIDTH(STAMP_ROW_W), .DEPTH(NUM_SETS)) u_stamp_ram (
        .i_clk     (i_clk),
        .i_wr_en   (stamp_we),
        .i_wr_addr (wr_set),
        .i_wr_data (stamp_wr),
        .i_rd_addr (rd_set),
        .o_rd_data (stamp_rd)
    );

    salru_ram #(.WIDTH(WAY_W), .DEPTH(NUM_SETS)) u_ptr_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ptr_we),
        .i_wr_addr (wr_set),
        .i_wr_data (ptr_wr),
        .i_rd_addr (rd_set),
        .o_rd_data (ptr_rd)
    );

    // hit search and victim choice
    always_comb begin
        tvld    = vld_rd;
        hit     = 1'b0;
        hit_way = '0;
        any_inv = 1'b0;
        inv_way = '0;
        lru_way = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            way_en[w] = (w == 0) || (w < int'(r_ways_in_use));
            stamp[w]  = stamp_rd[w*CNT_W +: CNT_W];
            match[w]  = way_en[w] && tvld[w] && (tag_rd[w*TAG_W +: TAG_W] == r_tag);
            inv[w]    = way_en[w] && !tvld[w];
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            win[w] = way_en[w];
            for (int j = 0; j < MAX_WAYS; j++) begin
                if (j < w && way_en[j] && !(stamp[w] < stamp[j])) begin
                    win[w] = 1'b0;
                end
                if (j > w && way_en[j] && (stamp[j] < stamp[w])) begin
                    win[w] = 1'b0;
                end
            end
        end
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (match[w]) begin
                hit     = 1'b1;
                hit_way = WAY_W'(w);
            end
            if (inv[w]) begin
                any_inv = 1'b1;
                inv_way = WAY_W'(w);
            end
            if (win[w]) begin
                lru_way = WAY_W'(w);
            end
        end
    end

    // round robin pointer
    always_comb begin
        p_raw  = ptr_rd;
        p_ok   = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (p_raw == WAY_W'(w) && way_en[w]) begin
                p_ok = 1'b1;
            end
        end
        fifo_way = p_ok ? p_raw : '0;
        p_inc    = {1'b0, fifo_way} + (WAY_W+1)'(1);
        inc_ok   = 1'b0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (p_inc == (WAY_W+1)'(w) && way_en[w]) begin
                inc_ok = 1'b1;
            end
        end
        ptr_wr = (inc_ok && !i_cmd.clear) ? p_inc[WAY_W-1:0] : '0;
    end

    always_comb begin
        if (hit) begin
            pick = hit_way;
        end else if (r_replace_mode == MODE_FIFO) begin
            pick = fifo_way;
        end else if (any_inv) begin
            pick = inv_way;
        end else begin
            pick = lru_way;
        end
    end

    assign acc_nxt  = r_accesses + CNT_W'(1);
    assign hits_nxt = r_hits + CNT_W'(hit);

    always_comb begin
        tag_wr   = tag_rd;
        stamp_wr = stamp_rd;
        vld_wr   = vld_rd;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (pick == WAY_W'(w)) begin
                tag_wr[w*TAG_W +: TAG_W]   = r_tag;
                stamp_wr[w*CNT_W +: CNT_W] = acc_nxt;
                vld_wr[w]                  = 1'b1;
            end
        end
        if (i_cmd.clear) begin
            tag_wr   = '0;
            stamp_wr = '0;
            vld_wr   = '0;
        end
    end

    assign tag_we   = i_cmd.clear || (i_cmd.commit && !hit);
    assign stamp_we = i_cmd.clear || (i_cmd.commit && (hit || r_replace_mode == MODE_LRU));
    assign ptr_we   = i_cmd.clear || (i_cmd.commit && !hit && r_replace_mode == MODE_FIFO);

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset_bits  <= RST_OFFSET_BITS;
            r_index_bits   <= RST_INDEX_BITS;
            r_ways_in_use  <= RST_WAYS_IN_USE;
            r_replace_mode <= MODE_LRU;
        end else if (i_cfg_wr_en) begin
            case (i_cfg_index)
                CFG_OFFSET_BITS:  r_offset_bits  <= i_cfg_data[OFF_CFG_W-1:0];
                CFG_INDEX_BITS:   r_index_bits   <= i_cfg_data[IDX_CFG_W-1:0];
                CFG_WAYS_IN_USE:  r_ways_in_use  <= i_cfg_data[WAYS_CFG_W-1:0];
                CFG_REPLACE_MODE: r_replace_mode <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    // clear counter and access counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_set  <= '0;
            r_hits     <= '0;
            r_accesses <= '0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_set <= r_clr_set + SET_W'(1);
            end
            if (i_cmd.commit) begin
                r_hits     <= hits_nxt;
                r_accesses <= acc_nxt;
            end
        end
    end

    // item registers and result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_set <= c_set;
            r_tag <= c_tag;
        end
        if (i_cmd.commit) begin
            o_hit             <= hit;
            o_way             <= OUT_WAY_W'(pick);
            o_set_index       <= OUT_SET_W'(r_set);
            o_hits_so_far     <= hits_nxt;
            o_accesses_so_far <= acc_nxt;
        end
    end

endmodule

`default_nettype wire

### hdl/salru_checker.sv
// ----------------------------------------------------------------------------
// salru_checker
// Port level checks of the tag lookup block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module salru_checker import salru_pkg::*; (
    input wire logic                  i_clk,
    input wire logic                  i_rst_n,
    input wire logic                  i_in_valid,
    input wire logic                  o_in_stall,
    input wire logic                  o_out_valid,
    input wire logic                  i_out_stall,
    input wire logic                  o_hit,
    input wire logic [OUT_WAY_W-1:0]  o_way,
    input wire logic [OUT_SET_W-1:0]  o_set_index,
    input wire logic [CNT_W-1:0]      o_hits_so_far,
    input wire logic [CNT_W-1:0]      o_accesses_so_far
);

    logic in_acc;
    logic out_held;
    logic [1+OUT_WAY_W+OUT_SET_W+2*CNT_W-1:0] res_bits;

    assign in_acc   = i_in_valid && !o_in_stall;
    assign out_held = o_out_valid && i_out_stall;
    assign res_bits = {o_hit, o_way, o_set_index, o_hits_so_far, o_accesses_so_far};

    `ASSERT_CLK(a_busy_after_accept, i_clk, i_rst_n, in_acc |=> o_in_stall, "accept while busy")
    `ASSERT_CLK(a_result_from_lookup, i_clk, i_rst_n, $rose(o_out_valid) |-> $past(o_in_stall), "result without lookup")
    `ASSERT_CLK(a_result_held, i_clk, i_rst_n, out_held |=> (o_out_valid && $stable(res_bits)), "stalled result changed")
    `ASSERT_CLK_NR(a_reset_clears, i_clk, !i_rst_n |=> (!o_out_valid && o_in_stall), "reset left handshake open")

endmodule

bind set_assoc_cache_tag_lru salru_checker u_salru_checker (.*);

`default_nettype wire
